[rtl/rdmp_pkg.sv]
`default_nettype none

package rdmp_pkg;

  // Store geometry.
  localparam int unsigned MAX_OUT_SITES = 256;
  localparam int unsigned MAX_IN_SITES  = 1024;
  localparam int unsigned MAX_FEATURES  = 64;
  localparam int unsigned MAX_WINDOW    = 64;

  localparam int unsigned SITE_DEPTH = MAX_OUT_SITES * MAX_FEATURES;
  localparam int unsigned GRAD_DEPTH = MAX_IN_SITES * MAX_FEATURES;
  localparam int unsigned SITE_AW    = $clog2(SITE_DEPTH);
  localparam int unsigned GRAD_AW    = $clog2(GRAD_DEPTH);
  localparam int unsigned ISITE_W    = $clog2(MAX_IN_SITES);

  // Field widths.
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned OSITE_W = 8;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned INS_W   = 11;
  localparam int unsigned FEAT_W  = 6;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned CFG_W   = 7;

  // Configuration port.
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic CFG_FEATURES = 1'b0;
  localparam logic CFG_WINDOW   = 1'b1;
  localparam logic [CFG_W-1:0] FEATURES_RESET = 7'd64;
  localparam logic [CFG_W-1:0] WINDOW_RESET   = 7'd9;

  // Request codes. Code 3 has no meaning and is dropped.
  typedef enum logic [REQ_W-1:0] {
    REQ_FWD  = 2'd0,
    REQ_BWD  = 2'd1,
    REQ_READ = 2'd2
  } req_t;

  localparam logic RES_POOL = 1'b0;
  localparam logic RES_GRAD = 1'b1;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [OSITE_W-1:0]       out_site;
    logic [SLOT_W-1:0]        slot;
    logic signed [INS_W-1:0]  in_site;
    logic [FEAT_W-1:0]        feature;
    logic signed [VAL_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic                     result_kind;
    logic signed [VAL_W-1:0]  result_value;
    logic [IDX_W-1:0]         chosen_index;
    logic                     window_empty;
    logic                     saturated;
  } result_t;

  typedef struct packed {
    logic                     seen;
    logic [IDX_W-1:0]         choice;
    logic signed [VAL_W-1:0]  best;
  } site_entry_t;

  typedef struct packed {
    logic                     sat;
    logic signed [VAL_W-1:0]  grad;
  } grad_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SITE_RD,
    ST_SITE_EVAL,
    ST_GRAD_RD,
    ST_GRAD_EVAL
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic ready;
    logic capture;
    logic clr;
    logic site_wr;
    logic load_choice;
    logic grad_wr;
    logic out_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic             clr_done;
    logic [REQ_W-1:0] in_req;
    logic             is_fwd;
    logic             is_bwd;
    logic             is_read;
    logic             last_slot;
    logic             seen;
    logic             empty_site;
    logic             out_busy;
  } sts_t;

endpackage

`default_nettype wire

[rtl/rdmp_item_if.sv]
`default_nettype none

interface rdmp_item_if;
  import rdmp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [OSITE_W-1:0]       out_site;
  logic [SLOT_W-1:0]        slot;
  logic signed [INS_W-1:0]  in_site;
  logic [FEAT_W-1:0]        feature;
  logic signed [VAL_W-1:0]  value;

  modport source (
    output valid, req_type, out_site, slot, in_site, feature, value,
    input  ready
  );

  modport sink (
    input  valid, req_type, out_site, slot, in_site, feature, value,
    output ready
  );
endinterface

`default_nettype wire

[rtl/rdmp_result_if.sv]
`default_nettype none

interface rdmp_result_if;
  import rdmp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     result_kind;
  logic signed [VAL_W-1:0]  result_value;
  logic [IDX_W-1:0]         chosen_index;
  logic                     window_empty;
  logic                     saturated;

  modport source (
    output valid, result_kind, result_value, chosen_index, window_empty, saturated,
    input  ready
  );

  modport sink (
    input  valid, result_kind, result_value, chosen_index, window_empty, saturated,
    output ready
  );
endinterface

`default_nettype wire

[rtl/rule_driven_max_pool_with_argmax_core.sv]
// Forward item: idle, window store read, update; on the last slot the pooled result goes
// into the output register in the update state, which holds while that register is busy.
// Backward item: idle, window store read, update, and when the window was seen a second
// read-modify-write on the gradient store. Read item: idle, gradient store read, update.
// Both stores have one registered read port. After reset a clearing pass zeroes the
// gradient and window stores; no item is taken during it, configuration writes are.
`default_nettype none

module rule_driven_max_pool_with_argmax_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rdmp_pkg::CFG_AW-1:0]       paddr,
  input  wire logic [rdmp_pkg::PDATA_W-1:0]      pwdata,
  output logic      [rdmp_pkg::PDATA_W-1:0]      prdata,
  output logic                                   pready,
  rdmp_item_if.sink                              item,
  rdmp_result_if.source                          result
);
  import rdmp_pkg::*;

  logic [CFG_W-1:0] cfg_features;
  logic [CFG_W-1:0] cfg_window;
  logic             cfg_write;
  logic             reg_sel;
  cmd_t             cmd;
  sts_t             sts;
  item_t            item_bus;
  logic             out_valid;
  result_t          out_q;

  // The configuration port never waits. A write lands in the access phase;
  // the register index is the word address, so bit 2 picks between the two.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_features <= FEATURES_RESET;
      cfg_window   <= WINDOW_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        CFG_FEATURES: cfg_features <= pwdata[CFG_W-1:0];
        CFG_WINDOW:   cfg_window   <= pwdata[CFG_W-1:0];
        default:      cfg_features <= cfg_features;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      CFG_FEATURES: prdata = PDATA_W'(cfg_features);
      CFG_WINDOW:   prdata = PDATA_W'(cfg_window);
      default:      prdata = '0;
    endcase
  end

  // Gather the input channel into one item word for the datapath.
  always_comb begin
    item_bus.req_type = item.req_type;
    item_bus.out_site = item.out_site;
    item_bus.slot     = item.slot;
    item_bus.in_site  = item.in_site;
    item_bus.feature  = item.feature;
    item_bus.value    = item.value;
  end

  // The controller admits one item at a time; it is ready only while idle.
  assign item.ready = cmd.ready;

  rdmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  rdmp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .item        (item_bus),
    .cfg_features(cfg_features),
    .cfg_window  (cfg_window),
    .result_ready(result.ready),
    .out_valid   (out_valid),
    .out_q       (out_q)
  );

  // The output register parts the two sides: a finished result waits here for its
  // transfer while the next item is already taken in.
  assign result.valid        = out_valid;
  assign result.result_kind  = out_q.result_kind;
  assign result.result_value = out_q.result_value;
  assign result.chosen_index = out_q.chosen_index;
  assign result.window_empty = out_q.window_empty;
  assign result.saturated    = out_q.saturated;

endmodule

`default_nettype wire

[rtl/rdmp_ram.sv]
`default_nettype none

module rdmp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

`default_nettype wire

[rtl/rdmp_ctrl.sv]
`default_nettype none

module rdmp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  input  wire rdmp_pkg::sts_t sts,
  output rdmp_pkg::cmd_t     cmd
);
  import rdmp_pkg::*;

  state_t state;
  state_t state_next;
  logic   fwd_hold;
  logic   read_hold;

  // A result that cannot be parked in the output register holds the step.
  assign fwd_hold  = sts.last_slot && sts.out_busy;
  assign read_hold = sts.out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          case (sts.in_req)
            REQ_FWD:  state_next = ST_SITE_RD;
            REQ_BWD:  state_next = ST_SITE_RD;
            REQ_READ: state_next = ST_GRAD_RD;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_SITE_RD: begin
        state_next = ST_SITE_EVAL;
      end
      ST_SITE_EVAL: begin
        if (sts.is_fwd) begin
          state_next = fwd_hold ? ST_SITE_EVAL : ST_IDLE;
        end else begin
          state_next = sts.seen ? ST_GRAD_RD : ST_IDLE;
        end
      end
      ST_GRAD_RD: begin
        state_next = ST_GRAD_EVAL;
      end
      ST_GRAD_EVAL: begin
        if (sts.is_read && read_hold) begin
          state_next = ST_GRAD_EVAL;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
      end
      ST_IDLE: begin
        cmd.ready   = 1'b1;
        cmd.capture = item_valid;
      end
      ST_SITE_EVAL: begin
        if (sts.is_fwd) begin
          cmd.site_wr  = !fwd_hold;
          cmd.out_load = !fwd_hold && sts.last_slot;
        end else begin
          cmd.load_choice = 1'b1;
        end
      end
      ST_GRAD_EVAL: begin
        if (sts.is_read) begin
          cmd.out_load = !read_hold;
          cmd.grad_wr  = !read_hold && !sts.empty_site;
        end else begin
          cmd.grad_wr = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_clear_ends_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR && sts.clr_done |=> state == ST_IDLE)
    else $error("clearing pass did not hand over to idle");

  // An unknown request code is dropped in idle, so only known codes start work.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && cmd.ready &&
    (sts.in_req == REQ_FWD || sts.in_req == REQ_BWD || sts.in_req == REQ_READ)
    |=> !cmd.ready)
    else $error("second item taken while one is in work");

endmodule

`default_nettype wire

[rtl/rdmp_datapath.sv]
`default_nettype none

module rdmp_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rdmp_pkg::cmd_t                cmd,
  output rdmp_pkg::sts_t                     sts,
  input  wire rdmp_pkg::item_t               item,
  input  wire logic [rdmp_pkg::CFG_W-1:0]    cfg_features,
  input  wire logic [rdmp_pkg::CFG_W-1:0]    cfg_window,
  input  wire logic                          result_ready,
  output logic                               out_valid,
  output rdmp_pkg::result_t                  out_q
);
  import rdmp_pkg::*;

  item_t              item_q;
  logic [GRAD_AW-1:0] grad_addr;
  logic [GRAD_AW-1:0] clr_cnt;
  logic [CFG_W-1:0]   feff;
  logic [CFG_W-1:0]   weff;
  logic [GRAD_AW-1:0] flat_in;

  site_entry_t        site_rd;
  site_entry_t        site_new;
  site_entry_t        site_wdata;
  logic [SITE_AW-1:0] site_addr;
  logic [SITE_AW-1:0] site_waddr;
  logic               site_we;

  grad_entry_t        grad_rd;
  grad_entry_t        grad_new;
  grad_entry_t        grad_wdata;
  logic [GRAD_AW-1:0] grad_waddr;
  logic               grad_we;

  logic               seen_cur;
  logic               cand_ok;
  logic               take;
  logic signed [VAL_W:0] sum;
  logic               ovf_pos;
  logic               ovf_neg;
  result_t            res_next;

  // Register values of zero act as one, values above the store limits as the limit.
  always_comb begin
    if (cfg_features == '0) begin
      feff = CFG_W'(1);
    end else if (cfg_features > CFG_W'(MAX_FEATURES)) begin
      feff = CFG_W'(MAX_FEATURES);
    end else begin
      feff = cfg_features;
    end
    if (cfg_window == '0) begin
      weff = CFG_W'(1);
    end else if (cfg_window > CFG_W'(MAX_WINDOW)) begin
      weff = CFG_W'(MAX_WINDOW);
    end else begin
      weff = cfg_window;
    end
  end

  // Flat input index of the incoming item, in_site * features + feature.
  always_comb begin
    logic [ISITE_W+CFG_W-1:0] prod;
    logic [ISITE_W+CFG_W-1:0] fsum;
    prod    = (ISITE_W+CFG_W)'(item.in_site[ISITE_W-1:0]) * (ISITE_W+CFG_W)'(feff);
    fsum    = prod + (ISITE_W+CFG_W)'(item.feature);
    flat_in = fsum[GRAD_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
    end
    if (cmd.capture) begin
      grad_addr <= flat_in;
    end else if (cmd.load_choice) begin
      grad_addr <= site_rd.choice[GRAD_AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + GRAD_AW'(1);
    end
  end

  // Window state lives at (out_site, feature).
  assign site_addr = {item_q.out_site, item_q.feature};

  // Forward step: slot zero opens a new window, so the stored entry counts as unseen.
  always_comb begin
    seen_cur = site_rd.seen && (item_q.slot != '0);
    cand_ok  = !item_q.in_site[INS_W-1];
    take     = cand_ok && (!seen_cur || ($signed(item_q.value) > $signed(site_rd.best)));
    site_new.seen   = seen_cur || cand_ok;
    site_new.choice = take ? IDX_W'(grad_addr) : site_rd.choice;
    site_new.best   = take ? item_q.value : site_rd.best;
  end

  // Backward step: saturating add into the gradient entry.
  always_comb begin
    sum     = $signed({grad_rd.grad[VAL_W-1], grad_rd.grad}) +
              $signed({item_q.value[VAL_W-1], item_q.value});
    ovf_pos = !sum[VAL_W] && sum[VAL_W-1];
    ovf_neg = sum[VAL_W] && !sum[VAL_W-1];
    grad_new.sat = grad_rd.sat || ovf_pos || ovf_neg;
    if (ovf_pos) begin
      grad_new.grad = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (ovf_neg) begin
      grad_new.grad = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      grad_new.grad = sum[VAL_W-1:0];
    end
  end

  // Write ports: the clearing pass after reset owns both stores.
  always_comb begin
    if (cmd.clr) begin
      site_we    = {1'b0, clr_cnt} < (GRAD_AW+1)'(SITE_DEPTH);
      site_waddr = clr_cnt[SITE_AW-1:0];
      site_wdata = '0;
      grad_we    = 1'b1;
      grad_waddr = clr_cnt;
      grad_wdata = '0;
    end else begin
      site_we    = cmd.site_wr;
      site_waddr = site_addr;
      site_wdata = site_new;
      grad_we    = cmd.grad_wr;
      grad_waddr = grad_addr;
      grad_wdata = sts.is_read ? grad_entry_t'('0) : grad_new;
    end
  end

  rdmp_ram #(
    .WIDTH($bits(site_entry_t)),
    .DEPTH(SITE_DEPTH)
  ) u_site_ram (
    .clk  (clk),
    .we   (site_we),
    .waddr(site_waddr),
    .wdata(site_wdata),
    .raddr(site_addr),
    .rdata(site_rd)
  );

  rdmp_ram #(
    .WIDTH($bits(grad_entry_t)),
    .DEPTH(GRAD_DEPTH)
  ) u_grad_ram (
    .clk  (clk),
    .we   (grad_we),
    .waddr(grad_waddr),
    .wdata(grad_wdata),
    .raddr(grad_addr),
    .rdata(grad_rd)
  );

  always_comb begin
    res_next = '0;
    if (sts.is_fwd) begin
      res_next.result_kind = RES_POOL;
      if (site_new.seen) begin
        res_next.result_value = site_new.best;
        res_next.chosen_index = site_new.choice;
      end else begin
        res_next.window_empty = 1'b1;
      end
    end else begin
      res_next.result_kind = RES_GRAD;
      if (!sts.empty_site) begin
        res_next.result_value = grad_rd.grad;
        res_next.chosen_index = IDX_W'(grad_addr);
        res_next.saturated    = grad_rd.sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_q <= res_next;
    end
  end

  always_comb begin
    sts.clr_done   = clr_cnt == GRAD_AW'(GRAD_DEPTH - 1);
    sts.in_req     = item.req_type;
    sts.is_fwd     = item_q.req_type == REQ_FWD;
    sts.is_bwd     = item_q.req_type == REQ_BWD;
    sts.is_read    = item_q.req_type == REQ_READ;
    sts.last_slot  = CFG_W'(item_q.slot) == (weff - CFG_W'(1));
    sts.seen       = site_rd.seen;
    sts.empty_site = item_q.in_site[INS_W-1];
    sts.out_busy   = out_valid && !result_ready;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !result_ready))
    else $error("pending result overwritten");

  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    !cmd.clr && sts.is_bwd && cmd.grad_wr && grad_rd.sat |-> grad_wdata.sat)
    else $error("saturation flag lost on accumulate");

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps

// Testbench for the rule-driven max pooling core with argmax and gradient scatter.
//
// Item transfers go in through the item interface and results come back through the
// result interface. Every accepted item is run through a local predictor that keeps its
// own copy of the window store (running maximum, winning flat index, seen bit per
// output site and feature), the gradient store with its saturation flags, and the two
// configuration registers. When the predictor says an item produces a result, the
// expected result is queued. A separate checker pops the oldest expectation on each
// result transfer and compares it field by field.
//
// The run starts with two short directed tests (pooling corner cases, then gradient
// accumulation and readback). These are followed by a series of random phases, each
// under its own register setting, the extremes among them. Registers are only written
// once the block has drained.
module tb_top;
  import rdmp_pkg::*;

  // Request code 3 has no meaning in the block; it must be dropped silently.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // The longest item is a backward item whose window was seen. The settle wait covers any
  // item still in flight that makes no result.
  localparam int SETTLE_CYCLES = 16;

  // The limit covers the clearing pass, which writes every gradient store entry, and
  // about 1100 items at worst, each with its time in the block, a sender gap and a long
  // receiver stall, with a margin of several times that total.
  localparam int CYCLE_LIMIT = 600000;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  rdmp_item_if item_bus ();
  rdmp_result_if res_bus ();

  rule_driven_max_pool_with_argmax_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item_bus),
    .result  (res_bus)
  );

  // ---------------------------------------------------------------------------
  // Predictor state. This is a private copy of the block's stores and registers.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] features_reg;
  logic [CFG_W-1:0] window_reg;

  int          best_mem   [SITE_DEPTH];
  bit [15:0]   choice_mem [SITE_DEPTH];
  bit          seen_mem   [SITE_DEPTH];
  int          grad_mem   [GRAD_DEPTH];
  bit          sat_mem    [GRAD_DEPTH];

  // The input site and feature that won each window. These only aim the reads in the
  // random traffic at entries that actually collect gradients.
  logic signed [INS_W-1:0] win_site [SITE_DEPTH];
  logic [FEAT_W-1:0]       win_feat [SITE_DEPTH];

  result_t pending_results[$];
  logic [SITE_AW-1:0] recent_windows[$];

  int error_count;
  int items_counted;
  int burst_left;
  int cycle_count;

  function automatic int active_features();
    if (features_reg == 0) return 1;
    if (features_reg > MAX_FEATURES) return MAX_FEATURES;
    return int'(features_reg);
  endfunction

  function automatic int active_window();
    if (window_reg == 0) return 1;
    if (window_reg > MAX_WINDOW) return MAX_WINDOW;
    return int'(window_reg);
  endfunction

  // The flat input index wraps at the gradient store depth. A feature at or above the
  // active feature count is not rejected.
  function automatic bit [15:0] flat_of(logic signed [INS_W-1:0] site, logic [FEAT_W-1:0] feat);
    return 16'((int'(site) * active_features() + int'(feat)) % int'(GRAD_DEPTH));
  endfunction

  // Apply one accepted item to the predictor state and say whether it makes a result.
  function automatic void pool_scatter_step(input item_t it, output bit emits,
                                            output result_t res);
    int w;
    int g;
    longint sum;
    w = int'({it.out_site, it.feature});
    emits = 1'b0;
    res = '0;
    case (it.req_type)
      REQ_FWD: begin
        // Slot zero opens a new window, so the first valid candidate always wins.
        if (it.slot == 0) seen_mem[w] = 1'b0;
        if (it.in_site >= 0) begin
          // Strictly greater only, so on a tie the earlier entry stays.
          if (!seen_mem[w] || int'(it.value) > best_mem[w]) begin
            best_mem[w] = it.value;
            choice_mem[w] = flat_of(it.in_site, it.feature);
            seen_mem[w] = 1'b1;
            win_site[w] = it.in_site;
            win_feat[w] = it.feature;
          end
        end
        if (int'(it.slot) == active_window() - 1) begin
          emits = 1'b1;
          res.result_kind = RES_POOL;
          if (seen_mem[w]) begin
            res.result_value = best_mem[w];
            res.chosen_index = choice_mem[w];
          end else begin
            res.window_empty = 1'b1;
          end
        end
      end
      REQ_BWD: begin
        // A gradient for a window that never saw a valid site is dropped.
        if (seen_mem[w]) begin
          g = int'(choice_mem[w]);
          sum = longint'(grad_mem[g]) + longint'(it.value);
          if (sum > longint'(VAL_MAX)) begin
            sum = longint'(VAL_MAX);
            sat_mem[g] = 1'b1;
          end
          if (sum < longint'(VAL_MIN)) begin
            sum = longint'(VAL_MIN);
            sat_mem[g] = 1'b1;
          end
          grad_mem[g] = int'(sum);
        end
      end
      REQ_READ: begin
        emits = 1'b1;
        res.result_kind = RES_GRAD;
        // An empty input site reads as zero and clears nothing.
        if (it.in_site >= 0) begin
          g = int'(flat_of(it.in_site, it.feature));
          res.result_value = grad_mem[g];
          res.chosen_index = 16'(g);
          res.saturated = sat_mem[g];
          grad_mem[g] = 0;
          sat_mem[g] = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, timeout and result checking.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Outputs are sampled at the rising edge, before the block's registers update.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing pending", res_bus.result_value, 0);
      end else begin
        want = pending_results.pop_front();
        if (res_bus.result_kind !== want.result_kind)
          report_mismatch("result_kind", res_bus.result_kind, want.result_kind);
        if (res_bus.result_value !== want.result_value)
          report_mismatch("result_value", res_bus.result_value, want.result_value);
        if (res_bus.chosen_index !== want.chosen_index)
          report_mismatch("chosen_index", res_bus.chosen_index, want.chosen_index);
        if (res_bus.window_empty !== want.window_empty)
          report_mismatch("window_empty", res_bus.window_empty, want.window_empty);
        if (res_bus.saturated !== want.saturated)
          report_mismatch("saturated", res_bus.saturated, want.saturated);
      end
    end
  end

  // The receiver cycles through stall modes of random length: always open, random
  // stalls, a fixed one-in-three pattern, and a starved mode with rare ready cycles.
  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PERIODIC,
    SINK_STARVED
  } sink_mode_t;

  initial begin : result_sink
    sink_mode_t mode;
    int span;
    int tick;
    res_bus.ready = 1'b0;
    tick = 0;
    forever begin
      mode = sink_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          SINK_OPEN:     res_bus.ready <= 1'b1;
          SINK_RANDOM:   res_bus.ready <= ($urandom_range(0, 3) != 0);
          SINK_PERIODIC: res_bus.ready <= (tick % 3 == 0);
          SINK_STARVED:  res_bus.ready <= ($urandom_range(0, 15) == 0);
          default:       res_bus.ready <= 1'b1;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration access. Each write is read back, and the predictor takes the value
  // at the write edge. The upper data bits carry noise, since only seven bits exist.
  // ---------------------------------------------------------------------------
  task automatic reg_write(input logic reg_sel, input logic [CFG_W-1:0] val);
    logic [PDATA_W-1:0] noisy;
    noisy = {$urandom()} & ~32'h7f | 32'(val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= noisy;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == CFG_FEATURES) features_reg = val;
    else window_reg = val;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(val)) report_mismatch("register readback", prdata, 32'(val));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Item sender. It works in bursts of random length with random gaps between them.
  // Sometimes a long burst with no gap gives stretches of back-to-back traffic.
  // ---------------------------------------------------------------------------
  task automatic send_item(input item_t it);
    int gap;
    bit emits;
    result_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        item_bus.valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 16);
    end
    @(negedge clk);
    item_bus.valid <= 1'b1;
    item_bus.req_type <= it.req_type;
    item_bus.out_site <= it.out_site;
    item_bus.slot <= it.slot;
    item_bus.in_site <= it.in_site;
    item_bus.feature <= it.feature;
    item_bus.value <= it.value;
    do @(posedge clk); while (!item_bus.ready);
    burst_left--;
    if (it.req_type != REQ_UNUSED) items_counted++;
    pool_scatter_step(it, emits, res);
    if (emits) pending_results.push_back(res);
  endtask

  function automatic item_t make_item(input logic [REQ_W-1:0] req, input logic [7:0] osite,
                                      input logic [5:0] slot, input logic signed [10:0] site,
                                      input logic [5:0] feat, input logic signed [31:0] val);
    item_t it;
    it.req_type = req;
    it.out_site = osite;
    it.slot = slot;
    it.in_site = site;
    it.feature = feat;
    it.value = val;
    return it;
  endfunction

  // Drop valid, wait until every expected result has come back, then let any item
  // that makes no result finish inside the block.
  task automatic settle_block();
    @(negedge clk);
    item_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_config(input logic [CFG_W-1:0] feats, input logic [CFG_W-1:0] wins);
    settle_block();
    reg_write(CFG_FEATURES, feats);
    reg_write(CFG_WINDOW, wins);
  endtask

  // ---------------------------------------------------------------------------
  // Random field sources.
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return int'($urandom_range(0, 2097152)) - 1048576;
      2: begin
        case ($urandom_range(0, 4))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      // A handful of distinct values, so ties happen often.
      default: return int'($urandom_range(0, 3)) <<< 16;
    endcase
  endfunction

  // Most sites are valid. About one in five is empty, down to the most negative code.
  function automatic logic signed [10:0] rand_site();
    if ($urandom_range(0, 4) == 0) return 11'(-int'($urandom_range(1, 1024)));
    if ($urandom_range(0, 9) == 0) return 11'sd1023;
    return 11'($urandom_range(0, 1023));
  endfunction

  function automatic logic [5:0] rand_feature();
    if ($urandom_range(0, 7) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, active_features() - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Traffic shapes.
  // ---------------------------------------------------------------------------

  // A well-formed window. Slots run from zero to the last one, and each slot carries
  // one candidate per feature in play.
  task automatic run_window();
    logic [7:0] osite;
    logic [5:0] feats[3];
    int nfeat;
    osite = 8'($urandom());
    nfeat = (active_window() > 16) ? 1 : $urandom_range(1, 3);
    for (int f = 0; f < nfeat; f++) feats[f] = rand_feature();
    for (int s = 0; s < active_window(); s++)
      for (int f = 0; f < nfeat; f++)
        send_item(make_item(REQ_FWD, osite, 6'(s), rand_site(), feats[f], rand_value()));
    for (int f = 0; f < nfeat; f++) begin
      recent_windows.push_back({osite, feats[f]});
      if (recent_windows.size() > 32) void'(recent_windows.pop_front());
    end
  endtask

  // Gradients into recently pooled windows, then reads, mostly of the winning entries.
  task automatic run_gradients();
    logic [SITE_AW-1:0] key;
    int n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      if (recent_windows.size() != 0) begin
        key = recent_windows[$urandom_range(0, recent_windows.size() - 1)];
        send_item(make_item(REQ_BWD, key[13:6], 6'($urandom()), rand_site(), key[5:0],
                            rand_value()));
        if ($urandom_range(0, 2) != 0 && seen_mem[key])
          send_item(make_item(REQ_READ, key[13:6], 6'($urandom()), win_site[key],
                              win_feat[key], rand_value()));
      end else begin
        send_item(make_item(REQ_READ, 8'($urandom()), 6'($urandom()), rand_site(),
                            rand_feature(), rand_value()));
      end
    end
  endtask

  // A window that starts late, ends early, or runs past its last slot.
  task automatic run_broken_window();
    logic [7:0] osite;
    logic [5:0] feat;
    int first;
    int last;
    osite = 8'($urandom());
    feat = rand_feature();
    first = $urandom_range(0, active_window() - 1);
    last = $urandom_range(first, (active_window() + 1 > 63) ? 63 : active_window() + 1);
    for (int s = first; s <= last; s++)
      send_item(make_item(REQ_FWD, osite, 6'(s), rand_site(), feat, rand_value()));
  endtask

  task automatic run_noise();
    int n;
    n = $urandom_range(1, 3);
    repeat (n)
      send_item(make_item(2'($urandom()), 8'($urandom()), 6'($urandom()), 11'($urandom()),
                          6'($urandom()), $urandom()));
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Pooling corner cases under four features and three slots. One window has a tie
  // at the maximum, which must keep the earlier site. Another starts with an empty
  // slot, holds the top output site and feature, and uses a feature beyond the active
  // count. A third has only empty slots. A candidate sits past the last slot, and an
  // unknown request code is sent.
  task automatic test_pool_edges();
    program_config(7'd4, 7'd3);
    send_item(make_item(REQ_FWD, 8'd0, 6'd0, 11'sd5, 6'd0, VAL_MAX));
    send_item(make_item(REQ_FWD, 8'd0, 6'd1, 11'sd9, 6'd0, VAL_MAX));
    send_item(make_item(REQ_FWD, 8'd0, 6'd2, 11'sd1023, 6'd0, VAL_MIN));
    send_item(make_item(REQ_FWD, 8'd255, 6'd0, -11'sd1, 6'd63, 32'sd77));
    send_item(make_item(REQ_FWD, 8'd255, 6'd1, 11'sd1023, 6'd63, -32'sd5));
    send_item(make_item(REQ_FWD, 8'd255, 6'd2, -11'sd1024, 6'd63, VAL_MAX));
    send_item(make_item(REQ_FWD, 8'd7, 6'd0, -11'sd1, 6'd1, 32'sd1));
    send_item(make_item(REQ_FWD, 8'd7, 6'd1, -11'sd3, 6'd1, 32'sd2));
    send_item(make_item(REQ_FWD, 8'd7, 6'd2, -11'sd1024, 6'd1, 32'sd3));
    send_item(make_item(REQ_FWD, 8'd3, 6'd63, 11'sd3, 6'd2, 32'sd1));
    send_item(make_item(REQ_UNUSED, 8'd255, 6'd63, 11'sd1023, 6'd63, VAL_MAX));
    settle_block();
  endtask

  // Gradient accumulation on the windows above. Positive and negative saturation are
  // followed by reads that report and clear the flag, and a second read sees zero. A
  // gradient into the empty window is dropped. A read of an empty site answers zero.
  task automatic test_gradient_edges();
    send_item(make_item(REQ_BWD, 8'd0, 6'd0, 11'sd0, 6'd0, VAL_MAX));
    send_item(make_item(REQ_BWD, 8'd0, 6'd0, 11'sd0, 6'd0, VAL_MAX));
    send_item(make_item(REQ_READ, 8'd0, 6'd0, 11'sd5, 6'd0, 32'sd0));
    send_item(make_item(REQ_READ, 8'd0, 6'd0, 11'sd5, 6'd0, 32'sd0));
    send_item(make_item(REQ_BWD, 8'd255, 6'd0, 11'sd0, 6'd63, VAL_MIN));
    send_item(make_item(REQ_BWD, 8'd255, 6'd0, 11'sd0, 6'd63, VAL_MIN));
    send_item(make_item(REQ_READ, 8'd255, 6'd0, 11'sd1023, 6'd63, 32'sd0));
    send_item(make_item(REQ_BWD, 8'd7, 6'd0, 11'sd0, 6'd1, 32'sd100));
    send_item(make_item(REQ_READ, 8'd7, 6'd0, -11'sd1, 6'd1, 32'sd0));
    settle_block();
  endtask

  // One random phase under the given register values. Most traffic is well-formed
  // windows and their gradients. The rest is broken windows and raw noise.
  task automatic test_random_traffic(input logic [CFG_W-1:0] feats,
                                     input logic [CFG_W-1:0] wins, input int quota);
    int start;
    program_config(feats, wins);
    recent_windows.delete();
    start = items_counted;
    while (items_counted - start < quota) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: run_window();
        6, 7:             run_gradients();
        8:                run_broken_window();
        default:          run_noise();
      endcase
    end
    settle_block();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_bus.valid = 1'b0;
    item_bus.req_type = REQ_FWD;
    item_bus.out_site = '0;
    item_bus.slot = '0;
    item_bus.in_site = '0;
    item_bus.feature = '0;
    item_bus.value = '0;
    features_reg = FEATURES_RESET;
    window_reg = WINDOW_RESET;
    error_count = 0;
    items_counted = 0;
    burst_left = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_pool_edges();
    test_gradient_edges();
    test_random_traffic(7'd64, 7'd9, 90);
    test_random_traffic(7'd4, 7'd3, 90);
    // Zero in either register acts as one.
    test_random_traffic(7'd0, 7'd0, 60);
    test_random_traffic(7'd1, 7'd1, 60);
    test_random_traffic(7'd64, 7'd64, 130);
    // Values above the maximum clamp to it.
    test_random_traffic(7'd127, 7'd127, 70);
    test_random_traffic(7'd100, 7'd2, 70);
    test_random_traffic(7'd17, 7'd5, 90);
    test_random_traffic(7'($urandom_range(1, 64)), 7'($urandom_range(1, 8)), 70);
    test_random_traffic(7'($urandom_range(1, 64)), 7'($urandom_range(1, 8)), 70);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
